>>> rtl/core/spfr_pkg.sv
`default_nettype none

package spfr_pkg;

    // Default payload buffer size; sets the largest frame and the length limit
    localparam int SPFR_BUFFER_SIZE = 64;

    // Fixed frame positions
    localparam int POS_DEST    = 2;
    localparam int POS_SOURCE  = 3;
    localparam int POS_CMD     = 4;
    localparam int POS_LENGTH  = 5;
    localparam int POS_PAYLOAD = 6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_VALUE  = 1'b1;

    localparam logic [7:0] HEADER_RESET = 8'hFF;
    localparam logic [7:0] CHECK_RESET  = 8'h00;

    // Per-byte status reported with every result
    typedef enum logic [2:0] {
        ST_WAIT     = 3'd0,
        ST_READY    = 3'd1,
        ST_HDR1     = 3'd2,
        ST_HDR2     = 3'd3,
        ST_LENGTH   = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_CHECK    = 3'd6,
        ST_TIMEOUT  = 3'd7
    } status_t;

endpackage

`default_nettype wire

>>> rtl/core/spfr_parser.sv
`default_nettype none

module spfr_parser
    import spfr_pkg::*;
#(
    parameter int BUFFER_SIZE = SPFR_BUFFER_SIZE,
    parameter int POS_W       = $clog2(BUFFER_SIZE + 1),
    parameter int LEN_W       = $clog2(BUFFER_SIZE - POS_LENGTH)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       rx_byte,
    input  wire logic             gap_expired,
    input  wire logic [7:0]       header_value,
    input  wire logic [7:0]       check_value,
    output status_t               status,
    output logic      [POS_W-1:0] byte_index,
    output logic      [7:0]       dest_out,
    output logic      [7:0]       source_out,
    output logic      [7:0]       command_out,
    output logic      [LEN_W-1:0] arg_count
);

    localparam logic [7:0] LEN_LIMIT = 8'(BUFFER_SIZE - POS_LENGTH);

    logic [POS_W-1:0] frame_pos_reg, frame_pos_next;
    logic [LEN_W-1:0] payload_len_reg, payload_len_next;
    logic [7:0]       dest_reg, dest_next;
    logic [7:0]       source_reg, source_next;
    logic [7:0]       command_reg, command_next;
    logic [POS_W-1:0] check_pos;
    logic             ready;

    // Check byte position from the length held now; a length byte never lands there
    assign check_pos = POS_W'(payload_len_reg) + POS_W'(POS_PAYLOAD);

    // Frame parse for the byte at the input
    always_comb begin
        frame_pos_next   = frame_pos_reg;
        payload_len_next = payload_len_reg;
        dest_next        = dest_reg;
        source_next      = source_reg;
        command_next     = command_reg;
        status           = ST_WAIT;
        ready            = 1'b0;
        if (gap_expired && frame_pos_reg != '0) begin
            frame_pos_next = '0;
            status         = ST_TIMEOUT;
        end else if (frame_pos_reg == '0) begin
            if (rx_byte != header_value) begin
                status = ST_HDR1;
            end else begin
                frame_pos_next = POS_W'(1);
            end
        end else if (frame_pos_reg == POS_W'(1)) begin
            if (rx_byte != header_value) begin
                frame_pos_next = '0;
                status         = ST_HDR2;
            end else begin
                frame_pos_next = POS_W'(2);
            end
        end else if (frame_pos_reg == POS_W'(POS_LENGTH) && rx_byte >= LEN_LIMIT) begin
            frame_pos_next = '0;
            status         = ST_LENGTH;
        end else begin
            if (frame_pos_reg == POS_W'(POS_LENGTH)) begin
                payload_len_next = rx_byte[LEN_W-1:0];
            end
            if (frame_pos_reg == POS_W'(POS_DEST)) begin
                dest_next = rx_byte;
            end
            if (frame_pos_reg == POS_W'(POS_SOURCE)) begin
                source_next = rx_byte;
            end
            if (frame_pos_reg == POS_W'(POS_CMD)) begin
                command_next = rx_byte;
            end
            if (frame_pos_reg >= POS_W'(BUFFER_SIZE)) begin
                frame_pos_next = '0;
                status         = ST_OVERFLOW;
            end else if (frame_pos_reg == check_pos) begin
                frame_pos_next = '0;
                if (rx_byte != check_value) begin
                    status = ST_CHECK;
                end else begin
                    status = ST_READY;
                    ready  = 1'b1;
                end
            end else begin
                frame_pos_next = frame_pos_reg + POS_W'(1);
            end
        end
    end

    // Result fields; header fields only shown with a complete frame
    always_comb begin
        byte_index  = frame_pos_reg;
        dest_out    = ready ? dest_reg : '0;
        source_out  = ready ? source_reg : '0;
        command_out = ready ? command_reg : '0;
        arg_count   = ready ? payload_len_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos_reg   <= '0;
            payload_len_reg <= '0;
            dest_reg        <= '0;
            source_reg      <= '0;
            command_reg     <= '0;
        end else if (step) begin
            frame_pos_reg   <= frame_pos_next;
            payload_len_reg <= payload_len_next;
            dest_reg        <= dest_next;
            source_reg      <= source_next;
            command_reg     <= command_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/spfr_out_buf.sv
`default_nettype none

module spfr_out_buf #(
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [DATA_W-1:0] out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] main_data_reg, main_data_next;
    logic [DATA_W-1:0] skid_data_reg, skid_data_next;
    logic              push, pop;

    // Ready is registered: only a full skid slot stops the input side
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    // Two-entry buffer: main holds the oldest transaction
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop && skid_valid_reg) begin
            main_data_next = skid_data_reg;
            if (push) begin
                skid_data_next = in_data;
            end else begin
                skid_valid_next = 1'b0;
            end
        end else if (pop) begin
            main_valid_next = push;
            main_data_next  = in_data;
        end else if (push && !main_valid_reg) begin
            main_valid_next = 1'b1;
            main_data_next  = in_data;
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/serial_packet_frame_receiver_core.sv
`default_nettype none

// Serial frame receiver. Each input transaction carries one received byte
// (s_tdata) and a gap-timeout flag (s_tuser); each produces exactly one
// result transaction with a status (m_tuser), the byte echoed, the frame
// position it was taken at and, on a good frame, destination, source,
// command and payload length. Frames are header, header, destination,
// source, command, length, payload, check byte; the check byte is compared
// with the check_value register (index 1), the headers with header_value
// (index 0, reset 0xFF). Throughput is one byte per clock while the output
// buffer's skid slot is free: the parse is a single compare-and-update
// step on the frame position register, and the result goes into that
// two-entry buffer, so a byte is still taken while one result waits.
module serial_packet_frame_receiver_core
    import spfr_pkg::*;
#(
    parameter int BUFFER_SIZE = SPFR_BUFFER_SIZE,
    parameter int POS_W       = $clog2(BUFFER_SIZE + 1),
    parameter int LEN_W       = $clog2(BUFFER_SIZE - POS_LENGTH),
    parameter int OUT_BITS    = 32 + POS_W + LEN_W,
    parameter int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_wdata,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // rx_byte
    input  wire logic                 s_tuser,   // gap_expired
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // byte_out, byte_index, dest_out, source_out, command_out, arg_count, zero pad
    output logic [OUT_W-1:0]          m_tdata,
    output logic [2:0]                m_tuser    // status
);

    localparam int PKT_W = OUT_W + 3;

    logic [7:0]       header_value_reg;
    logic [7:0]       check_value_reg;
    logic             step;
    status_t          status;
    logic [POS_W-1:0] byte_index;
    logic [7:0]       dest_out, source_out, command_out;
    logic [LEN_W-1:0] arg_count;
    logic [PKT_W-1:0] pkt, pkt_out;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_value_reg <= HEADER_RESET;
            check_value_reg  <= CHECK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_HEADER_VALUE: header_value_reg <= cfg_wdata;
                CFG_CHECK_VALUE:  check_value_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign step = s_tvalid && s_tready;

    spfr_parser #(
        .BUFFER_SIZE (BUFFER_SIZE),
        .POS_W       (POS_W),
        .LEN_W       (LEN_W)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .rx_byte      (s_tdata),
        .gap_expired  (s_tuser),
        .header_value (header_value_reg),
        .check_value  (check_value_reg),
        .status       (status),
        .byte_index   (byte_index),
        .dest_out     (dest_out),
        .source_out   (source_out),
        .command_out  (command_out),
        .arg_count    (arg_count)
    );

    // Pack result: status on top, then tdata fields from the lowest bit up
    assign pkt = {status,
                  OUT_W'({arg_count, command_out, source_out, dest_out,
                          byte_index, s_tdata})};

    spfr_out_buf #(
        .DATA_W (PKT_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (pkt),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (pkt_out)
    );

    assign m_tdata = pkt_out[OUT_W-1:0];
    assign m_tuser = pkt_out[PKT_W-1:OUT_W];

endmodule

`default_nettype wire

>>> verif/serial_packet_frame_receiver_core_tb.sv
`timescale 1ns / 1ps

module serial_packet_frame_receiver_core_tb;
    import spfr_pkg::*;

    localparam int OUT_W       = 48;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 5;
    localparam int PHASE_BYTES = 345;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 4;
    localparam int MAX_PRINTS  = 40;

    // One byte offered to the block, with an optional hand-typed expectation
    typedef struct packed {
        logic [7:0] rx;
        logic       gap;
        logic       typed;
        status_t    st;
        logic [6:0] idx;
    } byte_row_t;

    // What the block must report for one received byte
    typedef struct packed {
        status_t    status;
        logic [7:0] rx;
        logic [6:0] idx;
        logic [7:0] dest;
        logic [7:0] src;
        logic [7:0] cmd;
        logic [5:0] len;
    } byte_report_t;

    // Directed bytes: header errors, gap at position 0, length limit,
    // zero-length good frame, mid-frame timeout, check mismatch.
    localparam byte_row_t DIRECTED [29] = '{
        '{8'h00, 1'b0, 1'b1, ST_HDR1,    7'd0},
        '{8'hFF, 1'b1, 1'b1, ST_WAIT,    7'd0},
        '{8'h12, 1'b0, 1'b1, ST_HDR2,    7'd1},
        '{8'hFF, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'hFF, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h00, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'hFF, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'hA5, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h3B, 1'b0, 1'b1, ST_LENGTH,  7'd5},
        '{8'hFF, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'hFF, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h5A, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'hC3, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h01, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h00, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h00, 1'b0, 1'b1, ST_READY,   7'd6},
        '{8'hFF, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'hFF, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h80, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h7F, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'hFF, 1'b1, 1'b1, ST_TIMEOUT, 7'd4},
        '{8'hFF, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'hFF, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h00, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h00, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h00, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h01, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'hFF, 1'b0, 1'b0, ST_WAIT,    7'd0},
        '{8'h01, 1'b0, 1'b1, ST_CHECK,   7'd7}
    };

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]       cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [2:0]       m_tuser;

    // Parser mirror, advanced on every accepted input transaction
    int         rx_pos;
    int         rx_len;
    logic [7:0] rx_dest;
    logic [7:0] rx_src;
    logic [7:0] rx_cmd;
    logic [7:0] rx_hdr;
    logic [7:0] rx_chk;

    byte_report_t byte_reports_q [$];
    byte_row_t    typed_q [$];

    // Stimulus-side view of the registers and run control
    logic [7:0] hdr_setting;
    logic [7:0] chk_setting;
    bit         stall_en;
    bit         send_idle_en;
    bit         hold_req;
    int         errors;
    int         bytes_sent;
    int         phase_bytes_sent;
    int         held_cycles;
    int         cycle_count;
    int         status_seen [8];

    serial_packet_frame_receiver_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report(string what, int got, int want);
        if (errors < MAX_PRINTS)
            $display("ERROR %0t ns: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Frame parse of one byte; updates the mirror and returns the report
    function automatic byte_report_t parse_byte(logic [7:0] c, logic gap);
        byte_report_t r;
        int pos;
        pos = rx_pos;
        r = '0;
        r.status = ST_WAIT;
        r.rx = c;
        r.idx = pos[6:0];
        if (gap && pos != 0) begin
            rx_pos = 0;
            r.status = ST_TIMEOUT;
        end else if (pos == 0) begin
            if (c != rx_hdr) r.status = ST_HDR1;
            else rx_pos = 1;
        end else if (pos == 1) begin
            if (c != rx_hdr) begin
                rx_pos = 0;
                r.status = ST_HDR2;
            end else begin
                rx_pos = 2;
            end
        end else if (pos == POS_LENGTH && c >= SPFR_BUFFER_SIZE - POS_LENGTH) begin
            rx_pos = 0;
            r.status = ST_LENGTH;
        end else begin
            case (pos)
                POS_LENGTH: rx_len = c;
                POS_DEST:   rx_dest = c;
                POS_SOURCE: rx_src = c;
                POS_CMD:    rx_cmd = c;
                default: ;
            endcase
            if (pos >= SPFR_BUFFER_SIZE) begin
                rx_pos = 0;
                r.status = ST_OVERFLOW;
            end else if (pos == rx_len + POS_PAYLOAD) begin
                rx_pos = 0;
                if (c != rx_chk) begin
                    r.status = ST_CHECK;
                end else begin
                    r.status = ST_READY;
                    r.dest = rx_dest;
                    r.src = rx_src;
                    r.cmd = rx_cmd;
                    r.len = rx_len[5:0];
                end
            end else begin
                rx_pos = pos + 1;
            end
        end
        return r;
    endfunction

    // Prediction on input transactions, checking on result transactions
    always @(posedge aclk) begin : scoreboard
        byte_report_t exp_r;
        byte_row_t    row;
        if (!aresetn) begin
            rx_pos = 0;
            rx_len = 0;
            rx_dest = '0;
            rx_src = '0;
            rx_cmd = '0;
            rx_hdr = HEADER_RESET;
            rx_chk = CHECK_RESET;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_HEADER_VALUE: rx_hdr = cfg_wdata;
                    CFG_CHECK_VALUE:  rx_chk = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                exp_r = parse_byte(s_tdata, s_tuser);
                row = typed_q.pop_front();
                // hand-typed rows take precedence for status and position
                if (row.typed) begin
                    exp_r.status = row.st;
                    exp_r.idx = row.idx;
                end
                byte_reports_q.push_back(exp_r);
            end
            if (m_tvalid && m_tready) begin
                status_seen[m_tuser]++;
                if (byte_reports_q.size() == 0) begin
                    report("result with nothing pending, status", m_tuser, -1);
                end else begin
                    exp_r = byte_reports_q.pop_front();
                    if (m_tuser != exp_r.status)
                        report("status", m_tuser, exp_r.status);
                    if (m_tdata[7:0] != exp_r.rx)
                        report("byte_out", m_tdata[7:0], exp_r.rx);
                    if (m_tdata[14:8] != exp_r.idx)
                        report("byte_index", m_tdata[14:8], exp_r.idx);
                    if (m_tdata[22:15] != exp_r.dest)
                        report("dest_out", m_tdata[22:15], exp_r.dest);
                    if (m_tdata[30:23] != exp_r.src)
                        report("source_out", m_tdata[30:23], exp_r.src);
                    if (m_tdata[38:31] != exp_r.cmd)
                        report("command_out", m_tdata[38:31], exp_r.cmd);
                    if (m_tdata[44:39] != exp_r.len)
                        report("arg_count", m_tdata[44:39], exp_r.len);
                end
            end
        end
    end

    // Result side: random stall bursts, ready stretches, one long hold-off
    initial begin : receiver
        int n;
        m_tready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge aclk);
                    held_cycles++;
                end
                hold_req = 1'b0;
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    function automatic byte_row_t untyped_row(logic [7:0] b, logic g);
        return '{b, g, 1'b0, ST_WAIT, 7'd0};
    endfunction

    // Offer one byte and hold it until the block takes it
    task automatic put_byte(byte_row_t row);
        if (send_idle_en && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= row.rx;
        s_tuser <= row.gap;
        typed_q.push_back(row);
        bytes_sent++;
        phase_bytes_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait out every pending result plus the pipeline
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (byte_reports_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(logic [7:0] hdr, logic [7:0] chk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_HEADER_VALUE;
        cfg_wdata <= hdr;
        @(posedge aclk);
        cfg_index <= CFG_CHECK_VALUE;
        cfg_wdata <= chk;
        @(posedge aclk);
        cfg_we <= 1'b0;
        hdr_setting = hdr;
        chk_setting = chk;
    endtask

    // Mostly well-formed frames with random content; some noise, bad
    // headers, oversize lengths, bad check bytes, gaps and truncations
    task automatic send_frame();
        logic [7:0] fb [$];
        logic [7:0] rnd;
        int kind;
        int r;
        int len;
        int cut;
        int k;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 6)) begin
                rnd = 8'($urandom);
                put_byte(untyped_row(rnd, $urandom_range(0, 9) == 0));
            end
            return;
        end
        rnd = 8'($urandom);
        fb.push_back(kind < 14 ? rnd : hdr_setting);
        rnd = 8'($urandom);
        fb.push_back((kind >= 14 && kind < 18) ? rnd : hdr_setting);
        repeat (3) fb.push_back(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 55)      len = $urandom_range(0, 8);
        else if (r < 70) len = $urandom_range(9, 56);
        else if (r < 82) len = $urandom_range(57, 58);
        else             len = $urandom_range(59, 255);
        fb.push_back(8'(len));
        if (len < SPFR_BUFFER_SIZE - POS_LENGTH) begin
            for (k = 0; k < len; k++) fb.push_back(8'($urandom));
            if ($urandom_range(0, 5) == 0)
                fb.push_back(chk_setting ^ 8'($urandom_range(1, 255)));
            else
                fb.push_back(chk_setting);
        end
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, fb.size()) : fb.size();
        for (k = 0; k < cut; k++)
            put_byte(untyped_row(fb[k], $urandom_range(0, 59) == 0));
    endtask

    initial begin : stimulus
        int i;
        int phase;
        bit paused;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_HEADER_VALUE;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        hdr_setting = HEADER_RESET;
        chk_setting = CHECK_RESET;
        stall_en = 1'b1;
        send_idle_en = 1'b1;
        hold_req = 1'b0;
        paused = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < $size(DIRECTED); i++) put_byte(DIRECTED[i]);

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: set_config(8'h00, 8'hFF);
                1: set_config(8'hFF, 8'h00);
                3: set_config(8'hA5, 8'h5A);
                default: set_config(8'($urandom), 8'($urandom));
            endcase
            // back-pressure: block fills while the result side holds off
            if (phase == 2) hold_req = 1'b1;
            // closing stretch runs at full rate on both sides
            if (phase == PHASES - 1) begin
                stall_en = 1'b0;
                send_idle_en = 1'b0;
            end
            phase_bytes_sent = 0;
            while (phase_bytes_sent < PHASE_BYTES) begin
                send_frame();
                if (phase == 1 && !paused && phase_bytes_sent > PHASE_BYTES / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end
        drain();

        $display("Sent %0d bytes over %0d register settings, %0d-cycle result hold-off",
                 bytes_sent, PHASES + 1, held_cycles);
        $display("Seen: %0d ready, %0d check, %0d overflow, %0d length, %0d timeout",
                 status_seen[ST_READY], status_seen[ST_CHECK], status_seen[ST_OVERFLOW],
                 status_seen[ST_LENGTH], status_seen[ST_TIMEOUT]);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
